/* rtl/nst_pkg.sv */
package nst_pkg;

    localparam int NAME_W = 10;
    localparam int SLOT_W = 12;
    localparam int NIU_W  = 11;

    localparam logic [NIU_W-1:0] NIU_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_LOAD   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_PRESENT = 2'd3
    } status_t;

    typedef struct packed {
        op_t               opcode;
        logic [NAME_W-1:0] name;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot_out;
        status_t           status;
    } rsp_t;

    // valid bit array control from the decision stage
    typedef struct packed {
        logic set;
        logic clr;
        logic flush;
    } vb_ctl_t;

endpackage

/* rtl/name_to_slot_table_with_last_hit_core.sv */
// channel  | valid      | stall      | payload
// ---------+------------+------------+------------------------------
// request  | req_valid  | req_stall  | req  (opcode, name, slot)
// response | rsp_valid  | rsp_stall  | rsp  (found, slot_out, status)
// config   | psel/penable/pwrite, pready always high, one register
//
// one beat per cycle sustained while rsp_stall is low; each beat passes
// through the decision stage (table memory read registered at accept) and
// then sits in the response register
// reset clears valid flags, last-hit register and both stage valids; no
// clearing pass, clear all flushes every valid flop at once
// req_stall is high only while the decision stage holds a beat and the
// response register is full and stalled
module name_to_slot_table_with_last_hit_core #(
    parameter int NAMES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  nst_pkg::req_t       req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output nst_pkg::rsp_t       rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IW = $clog2(NAMES);
    localparam logic [16:0] NAMES_LIM = 17'(NAMES);

    logic [nst_pkg::NIU_W-1:0]  names_in_use;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    nst_pkg::req_t              s1_item_reg;
    logic                       byp_hit_reg;
    logic [nst_pkg::SLOT_W-1:0] byp_data_reg;

    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    nst_pkg::rsp_t              rsp_reg;
    nst_pkg::rsp_t              rsp_next;

    logic [nst_pkg::NAME_W-1:0] last_name_reg;
    logic [nst_pkg::NAME_W-1:0] last_name_next;
    logic [nst_pkg::SLOT_W-1:0] last_slot_reg;
    logic [nst_pkg::SLOT_W-1:0] last_slot_next;
    logic                       last_valid_reg;
    logic                       last_valid_next;

    logic                       req_accept;
    logic                       s1_adv;
    logic [IW-1:0]              req_idx;
    logic [IW-1:0]              s1_idx;
    logic                       vbit;
    logic [nst_pkg::SLOT_W-1:0] ram_rdata;
    logic [nst_pkg::SLOT_W-1:0] slot_rd;
    logic                       in_range;
    logic                       hit_last;
    logic                       wr_en;
    nst_pkg::vb_ctl_t           vb_ctl;

    nst_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .names_in_use (names_in_use)
    );

    assign s1_adv     = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = s1_valid_reg && !s1_adv;
    assign req_accept = req_valid && !req_stall;
    assign req_idx    = IW'(req.name);
    assign s1_idx     = IW'(s1_item_reg.name);

    nst_ram #(
        .WIDTH (nst_pkg::SLOT_W),
        .DEPTH (NAMES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_idx),
        .wdata (s1_item_reg.slot),
        .re    (req_accept),
        .raddr (req_idx),
        .rdata (ram_rdata)
    );

    nst_valid #(
        .NAMES (NAMES)
    ) u_valid (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (s1_idx),
        .ctl     (vb_ctl),
        .bit_out (vbit)
    );

    // a load committing on the same edge as the read is missed by the ram
    assign slot_rd  = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign in_range = ({1'b0, s1_item_reg.name} < names_in_use)
                      && (17'(s1_item_reg.name) < NAMES_LIM);
    assign hit_last = last_valid_reg && (last_name_reg == s1_item_reg.name);

    always_comb
    begin
        rsp_next        = '{found: 1'b0, slot_out: '0, status: nst_pkg::ST_OK};
        last_name_next  = last_name_reg;
        last_slot_next  = last_slot_reg;
        last_valid_next = last_valid_reg;
        wr_en           = 1'b0;
        vb_ctl          = '{set: 1'b0, clr: 1'b0, flush: 1'b0};

        if (s1_item_reg.opcode == nst_pkg::OP_CLEAR)
        begin
            vb_ctl.flush    = s1_adv;
            last_valid_next = 1'b0;
        end
        else if (!in_range)
        begin
            rsp_next.status = nst_pkg::ST_RANGE;
        end
        else
        begin
            case (s1_item_reg.opcode)
                nst_pkg::OP_LOOKUP:
                begin
                    if (hit_last)
                    begin
                        rsp_next.found    = 1'b1;
                        rsp_next.slot_out = last_slot_reg;
                    end
                    else if (!vbit)
                    begin
                        rsp_next.status = nst_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        rsp_next.found    = 1'b1;
                        rsp_next.slot_out = slot_rd;
                        last_name_next    = s1_item_reg.name;
                        last_slot_next    = slot_rd;
                        last_valid_next   = 1'b1;
                    end
                end
                nst_pkg::OP_LOAD:
                begin
                    if (vbit)
                    begin
                        rsp_next.status = nst_pkg::ST_PRESENT;
                    end
                    else
                    begin
                        wr_en      = s1_adv;
                        vb_ctl.set = s1_adv;
                    end
                end
                default:
                begin
                    if (!vbit)
                    begin
                        rsp_next.status = nst_pkg::ST_ABSENT;
                    end
                    else
                    begin
                        vb_ctl.clr = s1_adv;
                        if (last_name_reg == s1_item_reg.name)
                        begin
                            last_valid_next = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    assign s1_valid_next  = req_accept ? 1'b1 : (s1_valid_reg && !s1_adv);
    assign rsp_valid_next = s1_adv ? 1'b1 : (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            last_name_reg  <= '0;
            last_slot_reg  <= '0;
            last_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (s1_adv)
            begin
                last_name_reg  <= last_name_next;
                last_slot_reg  <= last_slot_next;
                last_valid_reg <= last_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg  <= req;
            byp_hit_reg  <= wr_en && (s1_idx == req_idx);
            byp_data_reg <= s1_item_reg.slot;
        end
        if (s1_adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.status == nst_pkg::ST_OK)
        else $error("found set on a failed beat");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != nst_pkg::ST_OK |-> rsp.slot_out == '0 && !rsp.found)
        else $error("failed beat carries a slot");

    a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_item_reg.opcode == nst_pkg::OP_CLEAR |=> !last_valid_reg)
        else $error("last-hit survived clear all");

    a_last_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(last_valid_reg) |-> $past(s1_adv && s1_item_reg.opcode == nst_pkg::OP_LOOKUP))
        else $error("last-hit set by something other than a lookup");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg && rsp_valid && rsp_stall)
        else $error("request stalled without a full response side");

endmodule

/* rtl/nst_ram.sv */
module nst_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/nst_valid.sv */
module nst_valid #(
    parameter int NAMES = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [$clog2(NAMES)-1:0] idx,
    input  nst_pkg::vb_ctl_t         ctl,
    output logic                     bit_out
);

    logic [NAMES-1:0] vb_reg;
    logic [NAMES-1:0] vb_next;

    always_comb
    begin
        vb_next = vb_reg;
        if (ctl.flush)
        begin
            vb_next = '0;
        end
        else if (ctl.set)
        begin
            vb_next[idx] = 1'b1;
        end
        else if (ctl.clr)
        begin
            vb_next[idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= '0;
        end
        else
        begin
            vb_reg <= vb_next;
        end
    end

    assign bit_out = vb_reg[idx];

endmodule

/* rtl/nst_regs.sv */
module nst_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [nst_pkg::NIU_W-1:0]  names_in_use
);

    localparam logic REG_NAMES_IN_USE = 1'b0;

    logic [nst_pkg::NIU_W-1:0] niu_reg;
    logic [nst_pkg::NIU_W-1:0] niu_next;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        niu_next = niu_reg;
        if (wr_en && paddr[2] == REG_NAMES_IN_USE)
        begin
            niu_next = pwdata[nst_pkg::NIU_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            niu_reg <= nst_pkg::NIU_RESET;
        end
        else
        begin
            niu_reg <= niu_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NAMES_IN_USE: prdata = {{(32 - nst_pkg::NIU_W){1'b0}}, niu_reg};
            default:          prdata = '0;
        endcase
    end

    assign names_in_use = niu_reg;

endmodule
